// File: sv/sprseq_pkg.sv
// ============================================================================
// Sprite sequencer package
// Shared constants, item codes and the word types of the two channels.
// ============================================================================
package sprseq_pkg;

  // Number of hardware sprites.
  localparam int NUM_SPRITES = 8;

  // Widths of the item fields.
  localparam int KIND_W  = 2;
  localparam int XPOS_W  = 9;
  localparam int MASK_W  = 8;
  localparam int INDEX_W = 3;
  localparam int DATA_W  = 24;
  localparam int COLOR_W = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_XPOS  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MULTICOLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPAND_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_ONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_TWO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIDE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_SS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_SB   = 3'd7;

  // Multicolor bit pair codes.
  localparam logic [1:0] PAIR_SHARED_ONE = 2'b01;
  localparam logic [1:0] PAIR_OWN        = 2'b10;

  // Input word.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [XPOS_W-1:0]  beam_x;
    logic [MASK_W-1:0]  display_mask;
    logic [MASK_W-1:0]  freeze_mask;
    logic [MASK_W-1:0]  stop_mask;
    logic               foreground;
    logic [INDEX_W-1:0] sprite_index;
    logic [DATA_W-1:0]  load_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic               pixel_valid;
    logic [COLOR_W-1:0] pixel_color;
    logic [INDEX_W-1:0] pixel_sprite;
    logic [MASK_W-1:0]  sprite_sprite_hits;
    logic [MASK_W-1:0]  sprite_background_hits;
    logic               irq_sprite_sprite;
    logic               irq_sprite_background;
  } out_word_t;

endpackage

// File: sv/sprseq_in_if.sv
// ============================================================================
// Sprite sequencer input channel
// Valid/ready channel that carries one input word per handshake.
// ============================================================================
interface sprseq_in_if;
  import sprseq_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/sprseq_out_if.sv
// ============================================================================
// Sprite sequencer result channel
// Valid/ready channel that carries one result word per handshake.
// ============================================================================
interface sprseq_out_if;
  import sprseq_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/sprite_pixel_sequencer_top.sv
// ============================================================================
// Sprite pixel sequencer
// Eight hardware sprites with shift registers, horizontal expansion,
// multicolor mode, priority selection and collision latches.
// ============================================================================
//
//  channel   direction  word         handshake
//  -------   ---------  ----------   ----------------------------
//  items     in         in_word_t    valid/ready
//  results   out        out_word_t   valid/ready
//  cfg       in         index/data   cfg_we, no back-pressure
//
// One word is accepted per cycle while the result register is not stalled; its
// result word passes through the input register, then the result register,
// where it is offered until it is taken.
// The sprite state is read and written in the second stage, so consecutive
// words see each other's updates with no gap.
// A stalled result register holds its word and the input register fills
// behind it; reset clears both stages, the sprite state and the latches.
module sprite_pixel_sequencer_top (
  input  logic                                clk,
  input  logic                                rst,
  sprseq_in_if.sink                           items,
  sprseq_out_if.source                        results,
  input  logic                                cfg_we,
  input  logic [sprseq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sprseq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sprseq_pkg::*;

  // Configuration registers.
  logic [MASK_W-1:0]              multicolor_mask;
  logic [MASK_W-1:0]              expand_x_mask;
  logic [NUM_SPRITES*COLOR_W-1:0] sprite_colors;
  logic [COLOR_W-1:0]             shared_color_one;
  logic [COLOR_W-1:0]             shared_color_two;
  logic                           hide_sprites;
  logic                           check_sprite_sprite;
  logic                           check_sprite_background;

  // Sprite state.
  logic [DATA_W-1:0] shift_data      [NUM_SPRITES];
  logic [1:0]        color_bits      [NUM_SPRITES];
  logic              expand_flop     [NUM_SPRITES];
  logic              multicolor_flop [NUM_SPRITES];
  logic [XPOS_W-1:0] sprite_x        [NUM_SPRITES];
  logic [NUM_SPRITES-1:0] active_mask;
  logic [MASK_W-1:0]      sprite_sprite_latch;
  logic [MASK_W-1:0]      sprite_background_latch;

  logic [DATA_W-1:0] shift_data_next      [NUM_SPRITES];
  logic [1:0]        color_bits_next      [NUM_SPRITES];
  logic              expand_flop_next     [NUM_SPRITES];
  logic              multicolor_flop_next [NUM_SPRITES];
  logic [XPOS_W-1:0] sprite_x_next        [NUM_SPRITES];
  logic [NUM_SPRITES-1:0] active_mask_next;
  logic [MASK_W-1:0]      sprite_sprite_latch_next;
  logic [MASK_W-1:0]      sprite_background_latch_next;

  // Pipeline registers.
  logic      s1_valid;
  in_word_t  s1_item;
  logic      out_valid;
  out_word_t out_word;
  out_word_t out_word_next;
  logic      out_free;

  // Colour of a bit pair for one sprite.
  function automatic logic [COLOR_W-1:0] pair_color(
    input logic [INDEX_W-1:0]             s,
    input logic [1:0]                     bits,
    input logic [NUM_SPRITES*COLOR_W-1:0] colors,
    input logic [COLOR_W-1:0]             one,
    input logic [COLOR_W-1:0]             two
  );
    logic [COLOR_W-1:0] c;
    case (bits)
      PAIR_SHARED_ONE: c = one;
      PAIR_OWN:        c = colors[{s, 2'b00} +: COLOR_W];
      default:         c = two;
    endcase
    return c;
  endfunction

  // Handshake: the input register moves on whenever the result register
  // is empty or being emptied.
  assign out_free      = !out_valid || results.ready;
  assign items.ready   = !s1_valid || out_free;
  assign results.valid = out_valid;
  assign results.data  = out_word;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      multicolor_mask         <= '0;
      expand_x_mask           <= '0;
      sprite_colors           <= '0;
      shared_color_one        <= '0;
      shared_color_two        <= '0;
      hide_sprites            <= 1'b0;
      check_sprite_sprite     <= 1'b1;
      check_sprite_background <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULTICOLOR: multicolor_mask         <= cfg_data[MASK_W-1:0];
        REG_EXPAND_X:   expand_x_mask           <= cfg_data[MASK_W-1:0];
        REG_COLORS:     sprite_colors           <= cfg_data[NUM_SPRITES*COLOR_W-1:0];
        REG_SHARED_ONE: shared_color_one        <= cfg_data[COLOR_W-1:0];
        REG_SHARED_TWO: shared_color_two        <= cfg_data[COLOR_W-1:0];
        REG_HIDE:       hide_sprites            <= cfg_data[0];
        REG_CHECK_SS:   check_sprite_sprite     <= cfg_data[0];
        REG_CHECK_SB:   check_sprite_background <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_item <= items.data;
    end
  end

  // Per-item update of the sprite state and the result word.
  always_comb begin
    logic [NUM_SPRITES-1:0] hit;
    logic                   act0;
    logic                   act;
    logic                   trig;
    logic                   fr;
    logic                   ef;
    logic                   mf;
    logic                   drop;
    logic [1:0]             cb;
    logic [DATA_W-1:0]      sd;
    logic                   multi;
    logic                   irq_ss;
    logic                   irq_sb;
    logic [INDEX_W-1:0]     who;

    shift_data_next              = shift_data;
    color_bits_next              = color_bits;
    expand_flop_next             = expand_flop;
    multicolor_flop_next         = multicolor_flop;
    sprite_x_next                = sprite_x;
    active_mask_next             = active_mask;
    sprite_sprite_latch_next     = sprite_sprite_latch;
    sprite_background_latch_next = sprite_background_latch;
    hit    = '0;
    multi  = 1'b0;
    irq_ss = 1'b0;
    irq_sb = 1'b0;
    who    = '0;
    act0 = 1'b0; act = 1'b0; trig = 1'b0; fr = 1'b0;
    ef = 1'b0; mf = 1'b0; drop = 1'b0; cb = '0; sd = '0;
    out_word_next = '0;

    case (s1_item.kind)
      KIND_LOAD: begin
        if ({1'b0, s1_item.sprite_index} < (INDEX_W+1)'(NUM_SPRITES)) begin
          shift_data_next[s1_item.sprite_index] = s1_item.load_value;
        end
      end
      KIND_XPOS: begin
        if ({1'b0, s1_item.sprite_index} < (INDEX_W+1)'(NUM_SPRITES)) begin
          sprite_x_next[s1_item.sprite_index] = s1_item.load_value[XPOS_W-1:0];
        end
      end
      KIND_CLEAR: begin
        sprite_sprite_latch_next     = '0;
        sprite_background_latch_next = '0;
      end
      default: begin
        // Each sprite: trigger, shift and draw test.
        for (int s = 0; s < NUM_SPRITES; s++) begin
          act0 = active_mask[s] && !s1_item.stop_mask[s];
          fr   = s1_item.freeze_mask[s];
          trig = s1_item.display_mask[s] && !act0 && !fr &&
                 (s1_item.beam_x == sprite_x[s]);
          act  = act0 || trig;
          ef   = trig || expand_flop[s];
          mf   = trig || multicolor_flop[s];
          cb   = color_bits[s];
          sd   = shift_data[s];
          drop = 1'b0;
          if (act && !fr) begin
            if (ef) begin
              if (multicolor_mask[s]) begin
                if (mf) begin
                  cb = sd[DATA_W-1 -: 2];
                end
                mf = !mf;
              end else begin
                cb = {sd[DATA_W-1], 1'b0};
              end
              sd = {sd[DATA_W-2:0], 1'b0};
              // Only a sprite that has just shifted can run empty and go idle.
              drop = (sd == '0) && (cb == '0);
            end
            ef = !ef || !expand_x_mask[s];
          end
          shift_data_next[s]      = sd;
          color_bits_next[s]      = cb;
          expand_flop_next[s]     = ef;
          multicolor_flop_next[s] = mf;
          active_mask_next[s]     = act && !drop;
          hit[s] = act && (cb != '0) && !hide_sprites;
        end

        // Lowest numbered drawing sprite wins.
        for (int s = NUM_SPRITES - 1; s >= 0; s--) begin
          if (hit[s]) begin
            who = INDEX_W'(s);
          end
        end

        // Collision latches and first-hit pulses.
        multi = |(hit & (hit - NUM_SPRITES'(1)));
        if (multi && check_sprite_sprite) begin
          irq_ss = (sprite_sprite_latch == '0);
          sprite_sprite_latch_next = sprite_sprite_latch | MASK_W'(hit);
        end
        if ((hit != '0) && s1_item.foreground && check_sprite_background) begin
          irq_sb = (sprite_background_latch == '0);
          sprite_background_latch_next = sprite_background_latch | MASK_W'(hit);
        end

        out_word_next.pixel_valid  = |hit;
        out_word_next.pixel_sprite = who;
        if (hit != '0) begin
          out_word_next.pixel_color = pair_color(who, color_bits_next[who],
            sprite_colors, shared_color_one, shared_color_two);
        end
        out_word_next.irq_sprite_sprite     = irq_ss;
        out_word_next.irq_sprite_background = irq_sb;
      end
    endcase

    out_word_next.sprite_sprite_hits     = sprite_sprite_latch_next;
    out_word_next.sprite_background_hits = sprite_background_latch_next;
  end

  // Sprite state commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SPRITES; s++) begin
        shift_data[s]      <= '0;
        color_bits[s]      <= '0;
        expand_flop[s]     <= 1'b0;
        multicolor_flop[s] <= 1'b0;
        sprite_x[s]        <= '0;
      end
      active_mask             <= '0;
      sprite_sprite_latch     <= '0;
      sprite_background_latch <= '0;
    end else if (s1_valid && out_free) begin
      shift_data              <= shift_data_next;
      color_bits              <= color_bits_next;
      expand_flop             <= expand_flop_next;
      multicolor_flop         <= multicolor_flop_next;
      sprite_x                <= sprite_x_next;
      active_mask             <= active_mask_next;
      sprite_sprite_latch     <= sprite_sprite_latch_next;
      sprite_background_latch <= sprite_background_latch_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_word <= out_word_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A sprite-sprite pulse comes with at least two sprites in the latch.
  a_irq_ss_latch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.irq_sprite_sprite) |->
      ($countones(out_word.sprite_sprite_hits) >= 2))
    else $error("sprite-sprite pulse without two latched sprites");

  // A sprite-background pulse comes with a non-empty latch.
  a_irq_sb_latch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.irq_sprite_background) |->
      (out_word.sprite_background_hits != '0))
    else $error("sprite-background pulse with empty latch");

  // No pixel drawn means colour, sprite number and both pulses are zero.
  a_no_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.pixel_valid) |->
      (out_word.pixel_color == '0 && out_word.pixel_sprite == '0 &&
       !out_word.irq_sprite_sprite && !out_word.irq_sprite_background))
    else $error("undrawn pixel carries colour, sprite or pulse");

  // A clear word leaves both latches empty.
  a_clear_latches: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free && s1_item.kind == KIND_CLEAR) |=>
      (sprite_sprite_latch == '0 && sprite_background_latch == '0))
    else $error("latches not cleared");
`endif

endmodule
